>>> rtl/core/wfmc_pkg.sv
// ----------------------------------------------------------------------------
// wfmc_pkg
// Shared types, register indexes, reset values and phase codes of the
// wall-follow mode controller.
// ----------------------------------------------------------------------------
package wfmc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_DRIVE_SPEED     = 3'd0;
    localparam logic [2:0] CFG_WALL_DISTANCE   = 3'd1;
    localparam logic [2:0] CFG_CRUISE_SPEED    = 3'd2;
    localparam logic [2:0] CFG_STEER_PUSH      = 3'd3;
    localparam logic [2:0] CFG_FOLLOW_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_DEPTH_THRESHOLD = 3'd5;
    localparam logic [2:0] CFG_FINISH_SAMPLES  = 3'd6;

    // Configuration reset values.
    localparam logic [6:0]  RST_DRIVE_SPEED     = 7'd100;
    localparam logic [15:0] RST_WALL_DISTANCE   = 16'd1000;
    localparam logic [6:0]  RST_CRUISE_SPEED    = 7'd80;
    localparam logic [6:0]  RST_STEER_PUSH      = 7'd10;
    localparam logic [15:0] RST_FOLLOW_LIMIT    = 16'd1500;
    localparam logic [15:0] RST_DEPTH_THRESHOLD = 16'd1000;
    localparam logic [15:0] RST_FINISH_SAMPLES  = 16'd300;

    // Phase codes as they appear on the result beat.
    localparam logic [2:0] PH_CODE_STRAIGHT = 3'd0;
    localparam logic [2:0] PH_CODE_ROTATE   = 3'd1;
    localparam logic [2:0] PH_CODE_FOLLOW   = 3'd2;
    localparam logic [2:0] PH_CODE_FINISH   = 3'd3;
    localparam logic [2:0] PH_CODE_DONE     = 3'd4;

    localparam int RANGE_W  = 16;
    localparam int DRIVE_W  = 8;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [4:0] {
        PH_STRAIGHT = 5'b00001,
        PH_ROTATE   = 5'b00010,
        PH_FOLLOW   = 5'b00100,
        PH_FINISH   = 5'b01000,
        PH_DONE     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [6:0]  drive_speed;
        logic [15:0] wall_distance;
        logic [6:0]  cruise_speed;
        logic [6:0]  steer_push;
        logic [15:0] follow_limit;
        logic [15:0] depth_threshold;
        logic [15:0] finish_samples;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] front_range;
        logic [RANGE_W-1:0] front_left_range;
        logic [RANGE_W-1:0] front_right_range;
        logic [RANGE_W-1:0] back_left_range;
        logic [RANGE_W-1:0] back_right_range;
        logic [RANGE_W-1:0] down_range;
    } sample_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic signed [DRIVE_W-1:0] front_heave_drive;
        logic signed [DRIVE_W-1:0] back_heave_drive;
        logic [2:0]                current_phase;
        logic                      mission_done;
    } result_t;

    typedef struct packed {
        phase_t                    phase;
        logic                      near_side;   // 0 left, 1 right
        logic [15:0]               finish_count;
        logic signed [DRIVE_W-1:0] held_heave;
    } state_t;

endpackage

>>> rtl/core/wfmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// wfmc_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module wfmc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output wfmc_pkg::cfg_t     cfg
);
    import wfmc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DRIVE_SPEED:     cfg_next.drive_speed     = cfg_wdata[6:0];
                CFG_WALL_DISTANCE:   cfg_next.wall_distance   = cfg_wdata;
                CFG_CRUISE_SPEED:    cfg_next.cruise_speed    = cfg_wdata[6:0];
                CFG_STEER_PUSH:      cfg_next.steer_push      = cfg_wdata[6:0];
                CFG_FOLLOW_LIMIT:    cfg_next.follow_limit    = cfg_wdata;
                CFG_DEPTH_THRESHOLD: cfg_next.depth_threshold = cfg_wdata;
                CFG_FINISH_SAMPLES:  cfg_next.finish_samples  = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_speed     <= RST_DRIVE_SPEED;
            cfg_reg.wall_distance   <= RST_WALL_DISTANCE;
            cfg_reg.cruise_speed    <= RST_CRUISE_SPEED;
            cfg_reg.steer_push      <= RST_STEER_PUSH;
            cfg_reg.follow_limit    <= RST_FOLLOW_LIMIT;
            cfg_reg.depth_threshold <= RST_DEPTH_THRESHOLD;
            cfg_reg.finish_samples  <= RST_FINISH_SAMPLES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/wfmc_decide.sv
// ----------------------------------------------------------------------------
// wfmc_decide
// Single-pass phase decision: resolves the whole phase cascade for one
// sample and produces the drives and the next controller state.
// ----------------------------------------------------------------------------
module wfmc_decide (
    input  wfmc_pkg::state_t  st,
    input  wfmc_pkg::cfg_t    cfg,
    input  wfmc_pkg::sample_t smp,
    output wfmc_pkg::state_t  st_next,
    output wfmc_pkg::result_t res
);
    import wfmc_pkg::*;

    function automatic logic signed [DRIVE_W-1:0] sat100(input logic signed [9:0] v);
        logic signed [DRIVE_W-1:0] r;
        if (v > 10'sd100)
            r = 8'sd100;
        else if (v < -10'sd100)
            r = -8'sd100;
        else
            r = v[DRIVE_W-1:0];
        return r;
    endfunction

    logic at_st, at_rot, at_fol, at_fin;
    logic st_stay, rot_stay, fol_stay, fin_stay, away, ns_eff;
    logic enter_rot, enter_fol, enter_fin;
    logic [15:0] cnt_used;
    logic signed [9:0] s10, c10, p10, left_raw, right_raw;
    logic signed [DRIVE_W-1:0] half8, heave, fh, bh;
    phase_t phase_fin;

    always_comb
    begin
        at_st  = 1'b0;
        at_rot = 1'b0;
        at_fol = 1'b0;
        at_fin = 1'b0;
        unique case (st.phase)
            PH_STRAIGHT: at_st  = 1'b1;
            PH_ROTATE:   at_rot = 1'b1;
            PH_FOLLOW:   at_fol = 1'b1;
            PH_FINISH:   at_fin = 1'b1;
            default:     ;   // done, and any code that cannot arise
        endcase
    end

    assign st_stay = (smp.front_range > cfg.wall_distance)
                  && (smp.front_left_range > cfg.wall_distance)
                  && (smp.front_right_range > cfg.wall_distance);

    // The nearer side is picked when straight ends; a tie goes right.
    assign ns_eff = (at_st && !st_stay)
                  ? !(smp.front_left_range < smp.front_right_range)
                  : st.near_side;

    assign rot_stay = ns_eff ? (smp.front_right_range < smp.back_right_range)
                             : (smp.front_left_range < smp.back_left_range);
    assign away     = ns_eff ? (smp.front_right_range > smp.back_right_range)
                             : (smp.front_left_range > smp.back_left_range);
    assign fol_stay = smp.front_range > cfg.follow_limit;

    // Entering finish from follow restarts the count.
    assign cnt_used = at_fin ? st.finish_count : 16'd0;
    assign fin_stay = cnt_used < cfg.finish_samples;

    assign enter_rot = at_rot || (at_st && !st_stay);
    assign enter_fol = at_fol || (enter_rot && !rot_stay);
    assign enter_fin = at_fin || (enter_fol && !fol_stay);

    assign s10   = signed'({3'b000, cfg.drive_speed});
    assign c10   = signed'({3'b000, cfg.cruise_speed});
    assign p10   = signed'({3'b000, cfg.steer_push});
    assign half8 = signed'({2'b00, cfg.drive_speed[6:1]});
    assign heave = (smp.down_range > cfg.depth_threshold) ? -half8 : half8;

    always_comb
    begin
        st_next = st;
        fh = heave;
        bh = heave;
        if (at_st && st_stay)
        begin
            phase_fin = PH_STRAIGHT;
            left_raw  = s10;
            right_raw = s10;
        end
        else if (enter_rot && rot_stay)
        begin
            phase_fin = PH_ROTATE;
            left_raw  = ns_eff ? -s10 : s10;
            right_raw = ns_eff ? s10 : -s10;
        end
        else if (enter_fol && fol_stay)
        begin
            phase_fin = PH_FOLLOW;
            left_raw  = (away == ns_eff) ? (c10 + p10) : (c10 - p10);
            right_raw = (away == ns_eff) ? (c10 - p10) : (c10 + p10);
        end
        else if (enter_fin && fin_stay)
        begin
            phase_fin = PH_FINISH;
            left_raw  = ns_eff ? -p10 : p10;
            right_raw = ns_eff ? p10 : -p10;
            fh = st.held_heave;
            bh = st.held_heave;
        end
        else
        begin
            phase_fin = PH_DONE;
            left_raw  = 10'sd0;
            right_raw = 10'sd0;
            fh = 8'sd0;
            bh = 8'sd0;
        end

        st_next.phase     = phase_fin;
        st_next.near_side = ns_eff;
        if (enter_fin)
            st_next.finish_count = fin_stay ? cnt_used + 16'd1 : cnt_used;
        if (phase_fin == PH_STRAIGHT || phase_fin == PH_ROTATE || phase_fin == PH_FOLLOW)
            st_next.held_heave = heave;
    end

    always_comb
    begin
        res.left_drive        = sat100(left_raw);
        res.right_drive       = sat100(right_raw);
        res.front_heave_drive = fh;
        res.back_heave_drive  = bh;
        res.mission_done      = (phase_fin == PH_DONE);
        unique case (phase_fin)
            PH_STRAIGHT: res.current_phase = PH_CODE_STRAIGHT;
            PH_ROTATE:   res.current_phase = PH_CODE_ROTATE;
            PH_FOLLOW:   res.current_phase = PH_CODE_FOLLOW;
            PH_FINISH:   res.current_phase = PH_CODE_FINISH;
            default:     res.current_phase = PH_CODE_DONE;
        endcase
    end

endmodule

>>> rtl/core/wall_follow_mode_controller_core.sv
// ----------------------------------------------------------------------------
// wall_follow_mode_controller_core
// Wall-follow phase controller: six range readings in, four thruster
// drives plus phase status out, one result beat per sample beat.
// ----------------------------------------------------------------------------
// Each sample beat is captured in an input register, decided by one short
// pass of comparators and small adders, and written to an output register
// together with the controller state update. A new sample is taken every
// cycle while the result side keeps up: the input register refills in the
// same cycle it hands its sample on, so the only thing that holds the pipe
// is back-pressure on m_tready. The phases straight, rotate, follow, finish
// and done may all change within one sample; the drives shown are those of
// the phase that is in force at the end of the sample, and current_phase
// reports that phase. The user must write configuration registers through
// the cfg port only while no sample is in flight; the block itself does not
// enforce this. The registers have no read-back.
// ----------------------------------------------------------------------------
module wall_follow_mode_controller_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_index,
    input  logic [15:0]                       cfg_wdata,
    // Sample stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // front_range, front_left_range, front_right_range,
    // back_left_range, back_right_range, down_range (16 bits each)
    input  logic [wfmc_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Drive stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // left_drive, right_drive, front_heave_drive, back_heave_drive (8 bits
    // signed each), current_phase (3 bits), mission_done (1 bit), 4 zero bits
    output logic [wfmc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import wfmc_pkg::*;

    cfg_t    cfg;
    sample_t smp_in;
    sample_t smp_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t res;
    result_t res_reg;
    state_t  st_reg;
    state_t  st_next;
    logic    advance;
    logic    in_fire;

    wfmc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the sample beat, first field in the lowest bits.
    always_comb
    begin
        smp_in.front_range       = s_tdata[15:0];
        smp_in.front_left_range  = s_tdata[31:16];
        smp_in.front_right_range = s_tdata[47:32];
        smp_in.back_left_range   = s_tdata[63:48];
        smp_in.back_right_range  = s_tdata[79:64];
        smp_in.down_range        = s_tdata[95:80];
    end

    // The held sample moves on whenever the result register is free or is
    // being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    wfmc_decide u_decide (
        .st      (st_reg),
        .cfg     (cfg),
        .smp     (smp_reg),
        .st_next (st_next),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg.phase        <= PH_STRAIGHT;
            st_reg.near_side    <= 1'b0;
            st_reg.finish_count <= 16'd0;
            st_reg.held_heave   <= 8'sd0;
        end
        else
        begin
            if (in_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            // The controller state moves exactly once per decided sample.
            if (advance)
                st_reg <= st_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            smp_reg <= smp_in;
        if (advance)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       res_reg.mission_done,
                       res_reg.current_phase,
                       res_reg.back_heave_drive,
                       res_reg.front_heave_drive,
                       res_reg.right_drive,
                       res_reg.left_drive};

endmodule

>>> rtl/core/wfmc_checker.sv
// ----------------------------------------------------------------------------
// wfmc_checker
// Port-level checks of the wall-follow mode controller, bound to the top.
// ----------------------------------------------------------------------------
module wfmc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [wfmc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import wfmc_pkg::*;

    logic       seen_reg;
    logic       done_seen_reg;
    logic [2:0] last_phase_reg;
    logic       out_fire;

    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            done_seen_reg  <= 1'b0;
            last_phase_reg <= PH_CODE_STRAIGHT;
        end
        else if (out_fire)
        begin
            seen_reg       <= 1'b1;
            done_seen_reg  <= done_seen_reg || m_tdata[35];
            last_phase_reg <= m_tdata[34:32];
        end
    end

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Phases never move backward from one result beat to the next.
    a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && seen_reg |-> m_tdata[34:32] >= last_phase_reg)
        else $error("phase went backward");

    // Once done, every later beat stays done.
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && done_seen_reg |-> m_tdata[35] && m_tdata[34:32] == PH_CODE_DONE)
        else $error("controller left the done phase");

    // A done beat stops every thruster.
    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[35] |-> m_tdata[31:0] == 32'd0)
        else $error("drives not stopped when done");

endmodule

bind wall_follow_mode_controller_core wfmc_checker u_wfmc_checker (.*);
